### rtl/core/sdes_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sdes_pkg;

    localparam int unsigned BLOCK_W   = 8;
    localparam int unsigned KEY_W     = 10;
    localparam int unsigned P10_TBL_W = 40;
    localparam int unsigned P8_TBL_W  = 32;
    localparam int unsigned IP_TBL_W  = 24;
    localparam int unsigned EP_TBL_W  = 16;
    localparam int unsigned P4_TBL_W  = 8;
    localparam int unsigned SBOX_W    = 32;
    localparam int unsigned CFG_DATA_W = 40;
    localparam int unsigned CFG_IDX_W  = 3;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_KEY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_P10   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_P8    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_P4    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SBOX0 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SBOX1 = 3'd7;

    // standard S-DES tables
    localparam logic [KEY_W-1:0]     KEY_RST   = 10'd0;
    localparam logic [P10_TBL_W-1:0] P10_RST   = 40'd375819297090;
    localparam logic [P8_TBL_W-1:0]  P8_RST    = 32'd2303145509;
    localparam logic [IP_TBL_W-1:0]  IP_RST    = 24'd13873321;
    localparam logic [EP_TBL_W-1:0]  EP_RST    = 16'd14739;
    localparam logic [P4_TBL_W-1:0]  P4_RST    = 8'd45;
    localparam logic [SBOX_W-1:0]    SBOX0_RST = 32'd3084393393;
    localparam logic [SBOX_W-1:0]    SBOX1_RST = 32'd3323187940;

    // Bit 0 is the leftmost bit everywhere, so position k of an n-bit
    // vector is v[n-1-k].

    function automatic logic [KEY_W-1:0] f_p10(input logic [KEY_W-1:0] key,
                                               input logic [P10_TBL_W-1:0] tbl);
        logic [KEY_W-1:0] res;
        logic [3:0]       idx;
        res = '0;
        for (int i = 0; i < 10; i++) begin
            idx = tbl[4*i +: 4];
            for (int j = 0; j < 10; j++) begin
                if (idx == 4'(j)) res[9-i] = key[9-j];
            end
        end
        return res;
    endfunction

    function automatic logic [BLOCK_W-1:0] f_p8(input logic [KEY_W-1:0] src,
                                                input logic [P8_TBL_W-1:0] tbl);
        logic [BLOCK_W-1:0] res;
        logic [3:0]         idx;
        res = '0;
        for (int i = 0; i < 8; i++) begin
            idx = tbl[4*i +: 4];
            for (int j = 0; j < 10; j++) begin
                if (idx == 4'(j)) res[7-i] = src[9-j];
            end
        end
        return res;
    endfunction

    function automatic logic [4:0] f_rot5(input logic [4:0] x, input int unsigned r);
        logic [9:0] dbl;
        dbl = {x, x} << r;
        return dbl[9:5];
    endfunction

    function automatic logic [BLOCK_W-1:0] f_ip(input logic [BLOCK_W-1:0] blk,
                                                input logic [IP_TBL_W-1:0] tbl);
        logic [BLOCK_W-1:0] res;
        res = '0;
        for (int i = 0; i < 8; i++) begin
            res[7-i] = blk[3'd7 - tbl[3*i +: 3]];
        end
        return res;
    endfunction

    // output position j is the OR of every input position i with ip[i] == j
    function automatic logic [BLOCK_W-1:0] f_ip_inv(input logic [BLOCK_W-1:0] blk,
                                                    input logic [IP_TBL_W-1:0] tbl);
        logic [BLOCK_W-1:0] res;
        res = '0;
        for (int i = 0; i < 8; i++) begin
            for (int j = 0; j < 8; j++) begin
                if (tbl[3*i +: 3] == 3'(j)) res[7-j] = res[7-j] | blk[7-i];
            end
        end
        return res;
    endfunction

    function automatic logic [1:0] f_sbox(input logic [SBOX_W-1:0] tbl,
                                          input logic [3:0] g);
        logic [3:0]        entry;
        logic [SBOX_W-1:0] shifted;
        // row from outer bits, column from inner bits
        entry   = {g[3], g[0], g[2], g[1]};
        shifted = tbl >> {entry, 1'b0};
        return shifted[1:0];
    endfunction

    function automatic logic [BLOCK_W-1:0] f_round(input logic [BLOCK_W-1:0] s,
                                                   input logic [BLOCK_W-1:0] sk,
                                                   input logic [EP_TBL_W-1:0] ep,
                                                   input logic [P4_TBL_W-1:0] p4,
                                                   input logic [SBOX_W-1:0] sb0,
                                                   input logic [SBOX_W-1:0] sb1);
        logic [3:0] right;
        logic [7:0] x;
        logic [3:0] comb;
        logic [3:0] p;
        right = s[3:0];
        for (int i = 0; i < 8; i++) begin
            x[7-i] = right[2'd3 - ep[2*i +: 2]];
        end
        x    = x ^ sk;
        comb = {f_sbox(sb0, x[7:4]), f_sbox(sb1, x[3:0])};
        for (int i = 0; i < 4; i++) begin
            p[3-i] = comb[2'd3 - p4[2*i +: 2]];
        end
        return {s[7:4] ^ p, right};
    endfunction

endpackage

`default_nettype wire

### rtl/core/sdes_block_cipher_unit.sv
// S-DES block cipher unit with run-time loadable key and tables.
//
// Input stream (s_axis_*): one 8-bit block per transfer; tuser selects
// encrypt (0) or decrypt (1). Output stream (m_axis_*): one 8-bit result
// per input transfer, in order.
// Configuration: write i_cfg_wdata to register i_cfg_index when i_cfg_we
// is high (0 key, 1 P10, 2 P8, 3 IP, 4 EP, 5 P4, 6 S0, 7 S1). Write only
// while no block is in flight.
//
// A block passes from the input register into the result register, where
// m_axis_tvalid rises. Throughput: one block per cycle while the receiver
// does not stall; subkey derivation and both rounds sit in the single logic
// stage between the input register and the result register.
// Reset (synchronous, active low) empties both stages and loads the
// standard S-DES tables with an all-zero key.
// When the receiver stalls, the result register holds its block and the
// input register still takes one more block; s_axis_tready drops only
// when both are full.
`timescale 1ns / 1ps
`default_nettype none

module sdes_block_cipher_unit
    import sdes_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire  [BLOCK_W-1:0]    s_axis_tdata,   // [7:0] data_block
    input  wire                   s_axis_tuser,   // [0] req_type
    output logic                  m_axis_tvalid,
    input  wire                   m_axis_tready,
    output logic [BLOCK_W-1:0]    m_axis_tdata,   // [7:0] result_block
    input  wire                   i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic [KEY_W-1:0]     r_key;
    logic [P10_TBL_W-1:0] r_p10;
    logic [P8_TBL_W-1:0]  r_p8;
    logic [IP_TBL_W-1:0]  r_ip;
    logic [EP_TBL_W-1:0]  r_ep;
    logic [P4_TBL_W-1:0]  r_p4;
    logic [SBOX_W-1:0]    r_sbox0;
    logic [SBOX_W-1:0]    r_sbox1;

    logic                 r_in_valid;
    logic                 r_in_decrypt;
    logic [BLOCK_W-1:0]   r_in_block;
    logic                 r_out_valid;
    logic [BLOCK_W-1:0]   r_out_block;

    logic                 w_out_free;
    logic [KEY_W-1:0]     w_p10;
    logic [4:0]           w_l1, w_r1, w_l2, w_r2;
    logic [BLOCK_W-1:0]   w_k1, w_k2, w_first, w_second;
    logic [BLOCK_W-1:0]   w_s0, w_s1, w_s2, w_s3, w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= KEY_RST;
            r_p10   <= P10_RST;
            r_p8    <= P8_RST;
            r_ip    <= IP_RST;
            r_ep    <= EP_RST;
            r_p4    <= P4_RST;
            r_sbox0 <= SBOX0_RST;
            r_sbox1 <= SBOX1_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_KEY:   r_key   <= i_cfg_wdata[KEY_W-1:0];
                REG_P10:   r_p10   <= i_cfg_wdata[P10_TBL_W-1:0];
                REG_P8:    r_p8    <= i_cfg_wdata[P8_TBL_W-1:0];
                REG_IP:    r_ip    <= i_cfg_wdata[IP_TBL_W-1:0];
                REG_EP:    r_ep    <= i_cfg_wdata[EP_TBL_W-1:0];
                REG_P4:    r_p4    <= i_cfg_wdata[P4_TBL_W-1:0];
                REG_SBOX0: r_sbox0 <= i_cfg_wdata[SBOX_W-1:0];
                REG_SBOX1: r_sbox1 <= i_cfg_wdata[SBOX_W-1:0];
            endcase
        end
    end

    // subkeys: P10, rotate halves by one for K1, by two more for K2
    always_comb begin
        w_p10 = f_p10(r_key, r_p10);
        w_l1  = f_rot5(w_p10[9:5], 1);
        w_r1  = f_rot5(w_p10[4:0], 1);
        w_l2  = f_rot5(w_l1, 2);
        w_r2  = f_rot5(w_r1, 2);
        w_k1  = f_p8({w_l1, w_r1}, r_p8);
        w_k2  = f_p8({w_l2, w_r2}, r_p8);
    end

    assign w_first  = r_in_decrypt ? w_k2 : w_k1;
    assign w_second = r_in_decrypt ? w_k1 : w_k2;

    always_comb begin
        w_s0     = f_ip(r_in_block, r_ip);
        w_s1     = f_round(w_s0, w_first, r_ep, r_p4, r_sbox0, r_sbox1);
        w_s2     = {w_s1[3:0], w_s1[7:4]};
        w_s3     = f_round(w_s2, w_second, r_ep, r_p4, r_sbox0, r_sbox1);
        w_result = f_ip_inv(w_s3, r_ip);
    end

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) r_in_valid <= s_axis_tvalid;
            if (w_out_free) r_out_valid <= r_in_valid;
        end
    end

    // payload: capture on transfer, advance when the result register frees up
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_decrypt <= s_axis_tuser;
            r_in_block   <= s_axis_tdata;
        end
        if (w_out_free && r_in_valid) r_out_block <= w_result;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_block;

endmodule

`default_nettype wire

### rtl/core/sdes_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module sdes_checker
    import sdes_pkg::*;
(
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   s_axis_tready,
    input wire                   m_axis_tvalid,
    input wire                   m_axis_tready,
    input wire  [BLOCK_W-1:0]    m_axis_tdata
);

    // reset empties the result register
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a stalled result holds its value
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // a ready receiver never backs up the input side
    a_ready_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output ready");

    // an empty result register leaves room for one more block
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output empty");

endmodule

bind sdes_block_cipher_unit sdes_checker u_sdes_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### test/sdes_result_checker.sv
`timescale 1ns / 1ps

module sdes_result_checker
    import sdes_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   s_axis_tvalid,
    input  wire                   s_axis_tready,
    input  wire  [BLOCK_W-1:0]    s_axis_tdata,   // [7:0] data_block
    input  wire                   s_axis_tuser,   // [0] req_type
    input  wire                   m_axis_tvalid,
    input  wire                   m_axis_tready,
    input  wire  [BLOCK_W-1:0]    m_axis_tdata,   // [7:0] result_block
    input  wire                   i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [CFG_DATA_W-1:0] i_cfg_wdata,
    output int                    o_pending,
    output int                    o_fail_count
);

    // shadow copy of the key and tables
    logic [KEY_W-1:0]     key_q;
    logic [P10_TBL_W-1:0] p10_q;
    logic [P8_TBL_W-1:0]  p8_q;
    logic [IP_TBL_W-1:0]  ip_q;
    logic [EP_TBL_W-1:0]  ep_q;
    logic [P4_TBL_W-1:0]  p4_q;
    logic [SBOX_W-1:0]    sbox0_q;
    logic [SBOX_W-1:0]    sbox1_q;

    logic [BLOCK_W-1:0] expected_results [$];
    logic [BLOCK_W-1:0] want;

    // position k counts from the leftmost bit of an n-bit vector
    function automatic logic pos_bit(input logic [9:0] v, input int n, input int k);
        if (k >= n) return 1'b0;
        return v[n-1-k];
    endfunction

    // output position i takes source position tbl[i]; out-of-range reads zero
    function automatic logic [9:0] gather(input logic [9:0] src, input int srcw,
                                          input logic [39:0] tbl, input int fw,
                                          input int outn);
        logic [9:0] acc;
        int         idx;
        int         i;
        acc = '0;
        for (i = 0; i < outn; i++) begin
            idx = int'((tbl >> (fw * i)) & ((40'd1 << fw) - 40'd1));
            acc = {acc[8:0], pos_bit(src, srcw, idx)};
        end
        return acc;
    endfunction

    function automatic logic [4:0] rotl5(input logic [4:0] x, input int r);
        return 5'(({5'b0, x} << r) | ({5'b0, x} >> (5 - r)));
    endfunction

    function automatic logic [1:0] sbox_val(input logic [SBOX_W-1:0] tbl,
                                            input logic [3:0] g);
        int e;
        // row from the outer bits, column from the inner bits
        e = int'({g[3], g[0]}) * 4 + int'({g[2], g[1]});
        return tbl[2*e +: 2];
    endfunction

    function automatic logic [7:0] feistel_round(input logic [7:0] s, input logic [7:0] sk);
        logic [9:0] ex;
        logic [7:0] x;
        logic [3:0] comb;
        logic [9:0] pm;
        ex   = gather({6'b0, s[3:0]}, 4, 40'(ep_q), 2, 8);
        x    = ex[7:0] ^ sk;
        comb = {sbox_val(sbox0_q, x[7:4]), sbox_val(sbox1_q, x[3:0])};
        pm   = gather({6'b0, comb}, 4, 40'(p4_q), 2, 4);
        return {s[7:4] ^ pm[3:0], s[3:0]};
    endfunction

    function automatic logic [7:0] sdes_transform(input logic decrypt, input logic [7:0] blk);
        logic [9:0] p10v;
        logic [4:0] l1;
        logic [4:0] r1;
        logic [4:0] l2;
        logic [4:0] r2;
        logic [9:0] k1;
        logic [9:0] k2;
        logic [9:0] ipv;
        logic [7:0] s;
        logic [7:0] res;
        int         i;
        p10v = gather(key_q, 10, p10_q, 4, 10);
        l1   = rotl5(p10v[9:5], 1);
        r1   = rotl5(p10v[4:0], 1);
        l2   = rotl5(l1, 2);
        r2   = rotl5(r1, 2);
        k1   = gather({l1, r1}, 10, 40'(p8_q), 4, 8);
        k2   = gather({l2, r2}, 10, 40'(p8_q), 4, 8);
        ipv  = gather({2'b0, blk}, 8, 40'(ip_q), 3, 8);
        s    = feistel_round(ipv[7:0], decrypt ? k2[7:0] : k1[7:0]);
        s    = {s[3:0], s[7:4]};
        s    = feistel_round(s, decrypt ? k1[7:0] : k2[7:0]);
        // inverse IP: OR every bit into the position its index names
        res = '0;
        for (i = 0; i < 8; i++) begin
            if (pos_bit({2'b0, s}, 8, i)) res[7 - int'(ip_q[3*i +: 3])] = 1'b1;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_q   = KEY_RST;
            p10_q   = P10_RST;
            p8_q    = P8_RST;
            ip_q    = IP_RST;
            ep_q    = EP_RST;
            p4_q    = P4_RST;
            sbox0_q = SBOX0_RST;
            sbox1_q = SBOX1_RST;
            expected_results.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result_block: expected nothing, actual %02h", m_axis_tdata);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_axis_tdata !== want) begin
                        $error("result_block: expected %02h, actual %02h", want, m_axis_tdata);
                        o_fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_results = {expected_results,
                                    sdes_transform(s_axis_tuser, s_axis_tdata)};
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_KEY:   key_q   = i_cfg_wdata[KEY_W-1:0];
                    REG_P10:   p10_q   = i_cfg_wdata[P10_TBL_W-1:0];
                    REG_P8:    p8_q    = i_cfg_wdata[P8_TBL_W-1:0];
                    REG_IP:    ip_q    = i_cfg_wdata[IP_TBL_W-1:0];
                    REG_EP:    ep_q    = i_cfg_wdata[EP_TBL_W-1:0];
                    REG_P4:    p4_q    = i_cfg_wdata[P4_TBL_W-1:0];
                    REG_SBOX0: sbox0_q = i_cfg_wdata[SBOX_W-1:0];
                    REG_SBOX1: sbox1_q = i_cfg_wdata[SBOX_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending = expected_results.size();
    end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import sdes_pkg::*;

    localparam logic REQ_ENCRYPT   = 1'b0;
    localparam logic REQ_DECRYPT   = 1'b1;
    localparam int   NUM_SEGMENTS  = 15;
    localparam int   SEG_ITEMS     = 100;
    localparam int   PRESSURE_SEG  = 3;
    localparam int   BURST_ITEMS   = 40;
    localparam int   LONG_HOLD     = 60;
    localparam int   SETTLE_CYCLES = 4;
    localparam int   STALL_LIMIT   = 2000;

    typedef enum int {TBL_STANDARD, TBL_SHUFFLED, TBL_RANDOM, TBL_EXTREME} tbl_mode_e;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [BLOCK_W-1:0]    s_axis_tdata;   // [7:0] data_block
    logic                  s_axis_tuser;   // [0] req_type
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [BLOCK_W-1:0]    m_axis_tdata;   // [7:0] result_block
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    int fail_count;
    int pending;
    int idle_cycles = 0;

    logic quiet        = 1'b0;
    logic hold_request = 1'b0;
    logic [CFG_DATA_W-1:0] cfg_next [8];

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    sdes_block_cipher_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    sdes_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    // stall the result side: long hold on request, short random bursts otherwise
    initial begin : sink_pacing
        m_axis_tready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_request = 1'b0;
                m_axis_tready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("sdes_block_cipher_unit regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [CFG_DATA_W-1:0] shuffled_indices(input int count, input int span,
                                                               input int fw);
        int pool [10];
        int i;
        int j;
        int t;
        logic [CFG_DATA_W-1:0] word;
        for (i = 0; i < span; i++) pool[i] = i;
        for (i = span - 1; i > 0; i--) begin
            j       = int'($urandom_range(0, i));
            t       = pool[i];
            pool[i] = pool[j];
            pool[j] = t;
        end
        word = '0;
        for (i = 0; i < count; i++) word = word | (CFG_DATA_W'(pool[i]) << (fw * i));
        return word;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_word();
        return CFG_DATA_W'({$urandom, $urandom});
    endfunction

    task automatic load_standard(input logic [CFG_DATA_W-1:0] key);
        cfg_next[REG_KEY]   = key;
        cfg_next[REG_P10]   = CFG_DATA_W'(P10_RST);
        cfg_next[REG_P8]    = CFG_DATA_W'(P8_RST);
        cfg_next[REG_IP]    = CFG_DATA_W'(IP_RST);
        cfg_next[REG_EP]    = CFG_DATA_W'(EP_RST);
        cfg_next[REG_P4]    = CFG_DATA_W'(P4_RST);
        cfg_next[REG_SBOX0] = CFG_DATA_W'(SBOX0_RST);
        cfg_next[REG_SBOX1] = CFG_DATA_W'(SBOX1_RST);
    endtask

    task automatic load_uniform(input logic [CFG_DATA_W-1:0] value);
        int r;
        for (r = 0; r < 8; r++) cfg_next[r] = value;
    endtask

    task automatic choose_settings();
        tbl_mode_e mode;
        int        r;
        mode = tbl_mode_e'($urandom_range(0, 3));
        case (mode)
            TBL_STANDARD: load_standard(rand_word());
            TBL_SHUFFLED: begin
                cfg_next[REG_KEY]   = rand_word();
                cfg_next[REG_P10]   = shuffled_indices(10, 10, 4);
                cfg_next[REG_P8]    = shuffled_indices(8, 10, 4);
                cfg_next[REG_IP]    = shuffled_indices(8, 8, 3);
                cfg_next[REG_EP]    = rand_word();
                cfg_next[REG_P4]    = shuffled_indices(4, 4, 2);
                cfg_next[REG_SBOX0] = rand_word();
                cfg_next[REG_SBOX1] = rand_word();
            end
            TBL_RANDOM: begin
                for (r = 0; r < 8; r++) cfg_next[r] = rand_word();
            end
            default: begin
                for (r = 0; r < 8; r++) cfg_next[r] = $urandom_range(0, 1) ? '1 : '0;
            end
        endcase
    endtask

    // write all eight registers back to back, then release the write enable
    task automatic apply_config();
        int r;
        for (r = 0; r < 8; r++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(r);
            i_cfg_wdata <= cfg_next[r];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // leaves tvalid high so the next block can follow without a bubble
    task automatic send_block(input logic req, input logic [BLOCK_W-1:0] blk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= blk;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_pair(input logic [BLOCK_W-1:0] blk);
        send_block(REQ_ENCRYPT, blk);
        send_block(REQ_DECRYPT, blk);
    endtask

    task automatic wait_empty();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        wait_empty();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic pace_sender();
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    initial begin : stimulus
        int seg;
        int n;
        logic pressure;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= REQ_ENCRYPT;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= REG_KEY;
        i_cfg_wdata   <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // tables as they come out of reset, all-zero key
        send_pair(8'h00);
        send_pair(8'hFF);
        send_pair(8'hA5);
        drain();

        // all ones: key extreme, out-of-range P10/P8 indices, IP folding onto one bit
        load_uniform('1);
        apply_config();
        send_pair(8'h00);
        send_pair(8'hFF);
        drain();

        // all zeros: every index names position zero
        load_uniform('0);
        apply_config();
        send_pair(8'h5A);
        send_pair(8'h81);
        drain();

        // standard tables, textbook key, upper P10 entries out of range
        load_standard(CFG_DATA_W'(10'b1010000010));
        cfg_next[REG_P10] = 40'hFEDCBA0000 | (CFG_DATA_W'(P10_RST) & 40'hFFFF);
        apply_config();
        send_pair(8'hB7);
        send_pair(8'h3C);
        drain();

        for (seg = 0; seg < NUM_SEGMENTS; seg++) begin
            quiet    = (seg >= NUM_SEGMENTS - 2);
            pressure = (seg == PRESSURE_SEG);
            choose_settings();
            apply_config();
            // keep offering while the result side holds off, so the input stalls
            if (pressure) hold_request = 1'b1;
            for (n = 0; n < SEG_ITEMS; n++) begin
                if (!pressure || n >= BURST_ITEMS) pace_sender();
                if (!quiet && $urandom_range(0, 199) == 0) begin
                    s_axis_tvalid <= 1'b0;
                    wait_empty();
                end
                send_block(1'($urandom_range(0, 1)), BLOCK_W'($urandom_range(0, 255)));
            end
            drain();
        end

        if (fail_count == 0 && pending == 0)
            $display("sdes_block_cipher_unit regression: pass");
        else
            $display("sdes_block_cipher_unit regression: fail");
        $finish;
    end

endmodule
